// ===== rtl/ntlv_pkg.sv =====
// ============================================================================
// ntlv_pkg
// Shared types and constants for the nested attribute message parser.
// ============================================================================
package ntlv_pkg;

   localparam int MAX_DEPTH = 16;
   localparam int POOL_SIZE = 64;
   localparam int LVL_W = $clog2(MAX_DEPTH + 1);
   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam logic [6:0] CAP_RESET = (POOL_SIZE > 127) ? 7'd127 : 7'(POOL_SIZE);
   localparam logic [16:0] POOL_LIMIT = 17'(POOL_SIZE);

   localparam logic [0:0] CSR_COMPACT = 1'b0;
   localparam logic [0:0] CSR_CAPACITY = 1'b1;

   localparam logic [2:0] EV_HEADER = 3'd0;
   localparam logic [2:0] EV_ATTR = 3'd1;
   localparam logic [2:0] EV_PAYLOAD = 3'd2;
   localparam logic [2:0] EV_OK = 3'd3;
   localparam logic [2:0] EV_FORMAT = 3'd4;
   localparam logic [2:0] EV_OVERFLOW = 3'd5;

   // Parsing section that the back publishes to the front.
   localparam logic [1:0] SECT_HEADER = 2'd0;
   localparam logic [1:0] SECT_ATTR = 2'd1;
   localparam logic [1:0] SECT_PAYLOAD = 2'd2;
   localparam logic [1:0] SECT_SKIP = 2'd3;

   // Message fault held until the closing byte.
   localparam logic [1:0] FAULT_NONE = 2'd0;
   localparam logic [1:0] FAULT_FORMAT = 2'd1;
   localparam logic [1:0] FAULT_OVERFLOW = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [15:0] protocol_id;
      logic [15:0] command_id;
      logic [15:0] top_count;
      logic [14:0] attribute_id;
      logic        has_children;
      logic [15:0] payload_size;
      logic [4:0]  nesting_level;
      logic [7:0]  payload_value;
      logic        run_end;
   } rsp_type;

   // Classified byte handed from the front to the back.
   typedef enum logic [1:0] {
      K_HDR_DONE,
      K_ATT_DONE,
      K_PAYLOAD,
      K_NONE
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        last_byte;
      logic [7:0]  data_byte;
      logic [15:0] f0;
      logic [15:0] f1;
      logic [15:0] f2;
      logic        flag;
   } token_type;

endpackage

// ===== rtl/ntlv_front.sv =====
// ============================================================================
// ntlv_front
// Assembles header bytes and tags each input byte for the back end.
// ============================================================================
module ntlv_front import ntlv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      compact,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req_data,
   // Section as seen by the back: header, attribute, payload or skip.
   input  logic [1:0] section,
   input  logic      sec_valid,
   output logic      tok_valid,
   output token_type tok_data,
   input  logic      tok_ready
);

   logic [2:0]  phase_ff, phase_in;
   logic [47:0] asm_ff, asm_in;
   logic [47:0] merged;
   logic        take;

   // The back publishes the section once all queued bytes are applied.
   assign req_ready = tok_ready && sec_valid;
   assign take = req_valid && req_ready;

   always_comb begin
      merged = asm_ff;
      if (phase_ff < 3'd6) begin
         merged[8*phase_ff +: 8] = req_data.data_byte;
      end
   end

   always_comb begin
      tok_data = '0;
      tok_data.kind = K_NONE;
      tok_data.last_byte = req_data.last_byte;
      tok_data.data_byte = req_data.data_byte;
      phase_in = phase_ff;
      asm_in = asm_ff;
      if (section == SECT_HEADER) begin
         if ((compact && phase_ff >= 3'd2) || phase_ff >= 3'd5) begin
            tok_data.kind = K_HDR_DONE;
            phase_in = '0;
            asm_in = '0;
            if (compact) begin
               tok_data.f0 = {8'd0, merged[7:0]};
               tok_data.f1 = {8'd0, merged[15:8]};
               tok_data.f2 = {8'd0, merged[23:16]};
            end else begin
               tok_data.f0 = merged[15:0];
               tok_data.f1 = merged[31:16];
               tok_data.f2 = merged[47:32];
            end
         end else begin
            phase_in = phase_ff + 3'd1;
            asm_in = merged;
         end
      end else if (section == SECT_ATTR) begin
         if ((compact && phase_ff >= 3'd1) || phase_ff >= 3'd3) begin
            tok_data.kind = K_ATT_DONE;
            phase_in = '0;
            asm_in = '0;
            if (compact) begin
               tok_data.flag = merged[7];
               tok_data.f0 = {9'd0, merged[6:0]};
               tok_data.f1 = {8'd0, merged[15:8]};
            end else begin
               tok_data.flag = merged[15];
               tok_data.f0 = {1'b0, merged[14:0]};
               tok_data.f1 = merged[31:16];
            end
         end else begin
            phase_in = phase_ff + 3'd1;
            asm_in = merged;
         end
      end else if (section == SECT_PAYLOAD) begin
         tok_data.kind = K_PAYLOAD;
      end
      // A closing byte, or a byte in the skip section, clears partial assembly.
      if (req_data.last_byte || section == SECT_SKIP) begin
         phase_in = '0;
         asm_in = '0;
      end
   end

   assign tok_valid = take;

   // Header and attribute assembly registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         asm_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         asm_ff <= asm_in;
      end
   end

endmodule

// ===== rtl/ntlv_queue.sv =====
// ============================================================================
// ntlv_queue
// Short token queue between the front and the back.
// ============================================================================
module ntlv_queue import ntlv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  token_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output token_type out_data,
   output logic      empty
);

   token_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   cnt_ff;

   assign in_ready = (cnt_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign empty = (cnt_ff == '0);
   assign out_data = mem_ff[rd_ff];

   // Pointer and count update.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (in_valid && in_ready) wr_ff <= wr_ff + 1'b1;
         if (out_valid && out_ready) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QPTR_W+1)'(in_valid && in_ready)
                   - (QPTR_W+1)'(out_valid && out_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) mem_ff[wr_ff] <= in_data;
   end

endmodule

// ===== rtl/ntlv_back.sv =====
// ============================================================================
// ntlv_back
// Applies tokens to the level stack and emits the result events.
// ============================================================================
module ntlv_back import ntlv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [6:0] capacity,
   input  logic       tok_valid,
   output logic       tok_ready,
   input  token_type  tok_data,
   output logic [1:0] section,
   output logic       busy,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   typedef enum logic [1:0] {
      S_RUN,
      S_POP,
      S_EMIT2
   } state_type;

   state_type         state_ff, state_in;
   logic [15:0]       stack_ff [MAX_DEPTH];
   logic [LVL_W-1:0]  ptr_ff, ptr_in;
   logic [1:0]        sec_ff, sec_in;
   logic [15:0]       left_ff, left_in;
   logic [16:0]       used_ff, used_in;
   logic [1:0]        err_ff, err_in;
   logic              done_ff, done_in;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   logic [15:0]       wr_val;
   logic              push_en;
   logic [IDX_W-1:0]  push_idx;
   logic [15:0]       push_val;
   rsp_type           out_ff, out_in;
   logic              ovalid_ff, ovalid_in;
   rsp_type           second_ff, second_in;
   logic              pend_last_ff, pend_last_in;
   logic [16:0]       cap_eff, sum;
   logic [IDX_W-1:0]  top_idx;
   logic              free;

   assign cap_eff = ({10'd0, capacity} > POOL_LIMIT) ? POOL_LIMIT : {10'd0, capacity};
   assign top_idx = IDX_W'(ptr_ff - 1'b1);
   assign free = !ovalid_ff || rsp_ready;
   assign tok_ready = (state_ff == S_RUN) && free;
   assign rsp_valid = ovalid_ff;
   assign rsp_data = out_ff;
   assign busy = (state_ff != S_RUN);
   // Bytes after an error, or after a finished tree, carry no parsing work.
   assign section = (err_ff != FAULT_NONE || done_ff) ? SECT_SKIP : sec_ff;

   always_comb begin
      rsp_type r;
      logic [15:0] rem;
      r = '0;
      rem = '0;
      state_in = state_ff;
      ptr_in = ptr_ff;
      sec_in = sec_ff;
      left_in = left_ff;
      used_in = used_ff;
      err_in = err_ff;
      done_in = done_ff;
      wr_en = 1'b0;
      wr_idx = top_idx;
      wr_val = '0;
      push_en = 1'b0;
      push_idx = top_idx;
      push_val = '0;
      out_in = out_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      second_in = second_ff;
      pend_last_in = pend_last_ff;
      sum = '0;
      unique case (state_ff)
         S_RUN: begin
            if (tok_valid && free) begin
               pend_last_in = tok_data.last_byte;
               r = '0;
               if (err_ff != FAULT_NONE) begin
                  // Silent until the closing byte.
               end else if (done_ff) begin
                  err_in = FAULT_FORMAT;
               end else begin
                  case (tok_data.kind)
                     K_HDR_DONE: begin
                        r.event_res = EV_HEADER;
                        r.protocol_id = tok_data.f0;
                        r.command_id = tok_data.f1;
                        r.top_count = tok_data.f2;
                        sum = used_ff + {1'b0, tok_data.f2};
                        if (tok_data.f2 == '0) begin
                           done_in = 1'b1;
                        end else if (sum > cap_eff) begin
                           err_in = FAULT_OVERFLOW;
                        end else begin
                           used_in = sum;
                           wr_en = 1'b1;
                           wr_idx = '0;
                           wr_val = tok_data.f2;
                           ptr_in = LVL_W'(1);
                           sec_in = SECT_ATTR;
                        end
                     end
                     K_ATT_DONE: begin
                        rem = stack_ff[top_idx];
                        if (ptr_ff != '0 && rem != '0) begin
                           wr_en = 1'b1;
                           wr_idx = top_idx;
                           wr_val = rem - 16'd1;
                        end
                        r.event_res = EV_ATTR;
                        r.attribute_id = tok_data.f0[14:0];
                        r.has_children = tok_data.flag;
                        r.payload_size = tok_data.f1;
                        r.nesting_level = 5'((ptr_ff != '0) ? ptr_ff - 1'b1 : '0);
                        sum = used_ff + {1'b0, tok_data.f1};
                        if (tok_data.flag) begin
                           if (sum > cap_eff) begin
                              err_in = FAULT_OVERFLOW;
                           end else if (tok_data.f1 != '0) begin
                              used_in = sum;
                              if (ptr_ff >= LVL_W'(MAX_DEPTH)) begin
                                 err_in = FAULT_OVERFLOW;
                              end else begin
                                 // The new level is written beside the
                                 // parent level's decrement.
                                 push_en = 1'b1;
                                 push_idx = IDX_W'(ptr_ff);
                                 push_val = tok_data.f1;
                                 ptr_in = ptr_ff + 1'b1;
                              end
                           end else begin
                              sec_in = SECT_ATTR;
                              state_in = S_POP;
                           end
                        end else if (tok_data.f1 != '0) begin
                           left_in = tok_data.f1;
                           sec_in = SECT_PAYLOAD;
                        end else begin
                           sec_in = SECT_ATTR;
                           state_in = S_POP;
                        end
                     end
                     K_PAYLOAD: begin
                        r.event_res = EV_PAYLOAD;
                        r.nesting_level = 5'((ptr_ff != '0) ? ptr_ff - 1'b1 : '0);
                        r.payload_value = tok_data.data_byte;
                        if (left_ff <= 16'd1) begin
                           left_in = '0;
                           sec_in = SECT_ATTR;
                           state_in = S_POP;
                        end else begin
                           left_in = left_ff - 16'd1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (state_in == S_POP) begin
                  // The closing event waits until the cascade settles.
                  second_in = r;
                  ovalid_in = ovalid_in;
               end else if (r.event_res != EV_HEADER || tok_data.kind == K_HDR_DONE) begin
                  if (err_ff == FAULT_NONE && !done_ff && tok_data.kind != K_NONE) begin
                     r.run_end = !tok_data.last_byte;
                     out_in = r;
                     ovalid_in = 1'b1;
                     if (tok_data.last_byte) begin
                        state_in = S_EMIT2;
                     end
                  end else if (tok_data.last_byte) begin
                     state_in = S_EMIT2;
                  end
               end else if (tok_data.last_byte) begin
                  state_in = S_EMIT2;
               end
            end
         end
         S_POP: begin
            // One level leaves the stack each cycle.
            if (ptr_ff != '0 && stack_ff[top_idx] == '0) begin
               ptr_in = ptr_ff - 1'b1;
            end else begin
               if (ptr_ff == '0) done_in = 1'b1;
               if (free) begin
                  r = second_ff;
                  r.run_end = !pend_last_ff;
                  out_in = r;
                  ovalid_in = 1'b1;
                  state_in = pend_last_ff ? S_EMIT2 : S_RUN;
               end
            end
         end
         S_EMIT2: begin
            if (free) begin
               r = '0;
               if (err_ff == FAULT_OVERFLOW) r.event_res = EV_OVERFLOW;
               else if (err_ff == FAULT_FORMAT || !done_ff) r.event_res = EV_FORMAT;
               else r.event_res = EV_OK;
               r.run_end = 1'b1;
               out_in = r;
               ovalid_in = 1'b1;
               state_in = S_RUN;
               ptr_in = '0;
               sec_in = SECT_HEADER;
               left_in = '0;
               used_in = '0;
               err_in = FAULT_NONE;
               done_in = 1'b0;
            end
         end
         default: state_in = S_RUN;
      endcase
   end

   // Control state and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
         ptr_ff <= '0;
         sec_ff <= SECT_HEADER;
         left_ff <= '0;
         used_ff <= '0;
         err_ff <= FAULT_NONE;
         done_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         pend_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         sec_ff <= sec_in;
         left_ff <= left_in;
         used_ff <= used_in;
         err_ff <= err_in;
         done_ff <= done_in;
         ovalid_ff <= ovalid_in;
         pend_last_ff <= pend_last_in;
      end
   end

   // Payload registers and level stack.
   always_ff @(posedge clock) begin
      out_ff <= out_in;
      second_ff <= second_in;
      if (wr_en) stack_ff[wr_idx] <= wr_val;
      if (push_en) stack_ff[push_idx] <= push_val;
   end

endmodule

// ===== rtl/nested_tlv_message_parser.sv =====
// ============================================================================
// nested_tlv_message_parser
// Streaming parser for nested attribute messages with level stack.
// ============================================================================
//  Channel | Ports                           | Moves
//  req     | req_valid/req_ready/req_data    | one message byte per transfer
//  rsp     | rsp_valid/rsp_ready/rsp_data    | one event per transfer
//  csr     | csr_write/csr_index/csr_data    | register write, no wait
//
// The front takes a byte only once the back has applied every queued
// byte, since the next byte's section depends on it. A finished
// attribute passes through the pop state, which pops each emptied level,
// and the closing byte is followed by a status event. Reset is synchronous
// and clears all control state. A stalled result holds the back; the front
// stops.
module nested_tlv_message_parser import ntlv_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_write,
   input  logic [0:0] csr_index,
   input  logic [6:0] csr_data
);

   logic       compact_ff;
   logic [6:0] capacity_ff;
   logic       ftok_valid, ftok_ready, btok_valid, btok_ready, q_empty, back_busy;
   token_type  ftok, btok;
   logic [1:0] section;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         compact_ff <= 1'b0;
         capacity_ff <= CAP_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_COMPACT: compact_ff <= csr_data[0];
            CSR_CAPACITY: capacity_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ntlv_front u_front (
      .clock(clock), .reset(reset), .compact(compact_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .section(section), .sec_valid(q_empty && !back_busy && !btok_valid),
      .tok_valid(ftok_valid), .tok_data(ftok), .tok_ready(ftok_ready)
   );

   ntlv_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(ftok_valid), .in_ready(ftok_ready), .in_data(ftok),
      .out_valid(btok_valid), .out_ready(btok_ready), .out_data(btok),
      .empty(q_empty)
   );

   ntlv_back u_back (
      .clock(clock), .reset(reset), .capacity(capacity_ff),
      .tok_valid(btok_valid), .tok_ready(btok_ready), .tok_data(btok),
      .section(section), .busy(back_busy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule
